### rtl/rrd_pkg.sv
package rrd_pkg;

    localparam int DIR_W         = 32;
    localparam int NORM_W        = 18;
    localparam int ETA_W         = 16;
    localparam int ETA_FRAC      = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 3;
    localparam int SQRT_STEPS    = 32;
    localparam int DT_W          = 21;
    localparam int OM_W          = 32;
    localparam int T_W           = 32;
    localparam int SQ_W          = 32;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sqs_t;

endpackage

### rtl/rrd_in_if.sv
interface rrd_in_if
    import rrd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [ETA_W-1:0]         eta;

    modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta,
                    input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta,
                  output ready);
endinterface

### rtl/rrd_out_if.sv
interface rrd_out_if
    import rrd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] out_x;
    logic signed [DIR_W-1:0] out_y;
    logic signed [DIR_W-1:0] out_z;
    logic                    refracted;

    modport source (output valid, out_x, out_y, out_z, refracted, input ready);
    modport sink (input valid, out_x, out_y, out_z, refracted, output ready);
endinterface

### rtl/ray_refraction_direction.sv
// Snell refraction of a Q.FRAC_BITS ray direction against a unit normal (Q2.FRAC_BITS)
// with index ratio eta (Q4.12). The unit takes one ray per clock cycle when the output is
// not stalled, and returns one result per ray, in order. The datapath contains the two
// 32-step square root pipelines (direction length and discriminant root) and the
// FRAC_BITS+1 step restoring divider that normalizes the direction. When the output is
// stalled the whole pipeline holds; nothing is dropped or repeated. A zero direction is
// treated as the zero vector; a non-positive discriminant returns the zero vector with
// refracted low. Output components saturate to the 32-bit signed range.
module ray_refraction_direction
    import rrd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rrd_in_if.sink    ray_in,
    rrd_out_if.source ray_out
);

    localparam int NUMW  = DIR_W + FRAC_BITS + 1;
    localparam int UW    = FRAC_BITS + 2;
    localparam int PW    = NORM_W + UW;
    localparam int DOTW  = PW + 2;
    localparam int DDW   = 2 * DT_W;
    localparam int NDW   = NORM_W + DT_W;
    localparam int EOW   = 65;
    localparam int ETW   = ETA_W + 1 + T_W;
    localparam int NSW   = NORM_W + SQ_W + 1;
    localparam int VW    = NSW + 2;
    localparam int DIVN  = FRAC_BITS + 1;
    localparam int I_S1  = 7;
    localparam int I_DV0 = I_S1 + SQRT_STEPS;
    localparam int I_DVL = I_DV0 + DIVN;
    localparam int NST   = 83 + FRAC_BITS;

    localparam logic signed [DOTW-1:0] DOT_HALF = DOTW'(1) << (FRAC_BITS - 1);
    localparam logic signed [DDW-1:0]  DD_HALF  = DDW'(1) << (FRAC_BITS - 1);
    localparam logic signed [DDW-1:0]  DD_ONE   = DDW'(1) << FRAC_BITS;
    localparam logic signed [NDW-1:0]  ND_HALF  = NDW'(1) << (FRAC_BITS - 1);
    localparam logic signed [EOW-1:0]  EO_HALF  = EOW'(1) << (2 * ETA_FRAC - 1);
    localparam logic signed [EOW-1:0]  EO_ONE   = EOW'(1) << FRAC_BITS;
    localparam logic signed [ETW-1:0]  ET_HALF  = ETW'(1) << (ETA_FRAC - 1);
    localparam logic signed [NSW-1:0]  NS_HALF  = NSW'(1) << (FRAC_BITS - 1);
    localparam logic signed [VW-1:0]   V_MAX    = VW'(32'h7fff_ffff);
    localparam logic signed [VW-1:0]   V_MIN    = -VW'(33'h0_8000_0000);

    typedef struct packed {
        logic [LANES-1:0]                   neg;
        logic [LANES-1:0][NORM_W-1:0]       n;
        logic [ETA_W-1:0]                   eta;
        logic                               zero;
        logic [LANES-1:0][DIR_W-1:0]        a;
    } fr_t;

    typedef struct packed {
        logic [LANES-1:0]                   neg;
        logic [LANES-1:0][NORM_W-1:0]       n;
        logic [ETA_W-1:0]                   eta;
        logic                               zero;
        logic [DIR_W-1:0]                   m;
        logic [LANES-1:0][NUMW-1:0]         num;
        logic [LANES-1:0][DIR_W-1:0]        rem;
        logic [LANES-1:0][FRAC_BITS:0]      q;
    } dv_t;

    typedef struct packed {
        logic [LANES-1:0][NORM_W-1:0]       n;
        logic [ETA_W-1:0]                   eta;
        logic [LANES-1:0][T_W-1:0]          t;
        logic                               pos;
    } bk_t;

    function automatic sqs_t sqrt_step(input sqs_t s, input int unsigned i);
        logic [63:0] b;
        logic [63:0] trial;
        sqs_t        o;
        b     = 64'd1 << (62 - 2 * i);
        trial = s.r + b;
        o     = s;
        if (s.x >= trial)
        begin
            o.x = s.x - trial;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic logic [DIR_W:0] div_step(input logic [DIR_W-1:0] rem,
                                                input logic [DIR_W-1:0] m,
                                                input logic nb);
        logic [DIR_W:0] t;
        t = {rem, nb};
        if (t >= {1'b0, m})
            return {1'b1, DIR_W'(t - {1'b0, m})};
        return {1'b0, t[DIR_W-1:0]};
    endfunction

    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv          = !vld_reg[NST-1] || ray_out.ready;
    assign ray_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], ray_in.valid};
    end

    // front: capture, magnitude, max, shift count, scale, squares, sum
    logic [LANES-1:0][DIR_W-1:0]  d0_reg;
    logic [LANES-1:0][NORM_W-1:0] n0_reg;
    logic [ETA_W-1:0]             eta0_reg;
    fr_t                          a1c_reg, a2c_reg, a3c_reg, a4c_reg, a5c_reg, a6c_reg;
    fr_t                          a1c_next, a3c_next, a4c_next;
    logic [DIR_W-1:0]             mx_reg, mx_next;
    logic [4:0]                   k_reg, k_next;
    logic [LANES-1:0][63:0]       sqr_reg;
    logic [63:0]                  sum_reg;

    always_comb
    begin
        a1c_next      = '0;
        a1c_next.n    = n0_reg;
        a1c_next.eta  = eta0_reg;
        for (int i = 0; i < LANES; i++)
        begin
            a1c_next.neg[i] = d0_reg[i][DIR_W-1];
            a1c_next.a[i]   = d0_reg[i][DIR_W-1] ? -d0_reg[i] : d0_reg[i];
        end
    end

    always_comb
    begin
        mx_next = a1c_reg.a[0];
        if (a1c_reg.a[1] > mx_next)
            mx_next = a1c_reg.a[1];
        if (a1c_reg.a[2] > mx_next)
            mx_next = a1c_reg.a[2];
    end

    always_comb
    begin
        a3c_next      = a2c_reg;
        a3c_next.zero = (mx_reg == '0);
    end

    always_comb
    begin
        k_next = '0;
        for (int b = 0; b < DIR_W - 1; b++)
        begin
            if (mx_reg[b])
                k_next = 5'(DIR_W - 2 - b);
        end
    end

    always_comb
    begin
        a4c_next = a3c_reg;
        for (int i = 0; i < LANES; i++)
            a4c_next.a[i] = a3c_reg.a[i] << k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg   <= {ray_in.dir_z, ray_in.dir_y, ray_in.dir_x};
            n0_reg   <= {ray_in.norm_z, ray_in.norm_y, ray_in.norm_x};
            eta0_reg <= ray_in.eta;
            a1c_reg  <= a1c_next;
            a2c_reg  <= a1c_reg;
            mx_reg   <= mx_next;
            a3c_reg  <= a3c_next;
            k_reg    <= k_next;
            a4c_reg  <= a4c_next;
            a5c_reg  <= a4c_reg;
            for (int i = 0; i < LANES; i++)
                sqr_reg[i] <= 64'(a4c_reg.a[i]) * 64'(a4c_reg.a[i]);
            a6c_reg  <= a5c_reg;
            sum_reg  <= sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
        end
    end

    // length of the scaled direction
    sqs_t s1_reg  [SQRT_STEPS];
    fr_t  s1c_reg [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sq1
        if (g == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s1_reg[g]  <= sqrt_step({sum_reg, 64'd0}, g);
                    s1c_reg[g] <= a6c_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s1_reg[g]  <= sqrt_step(s1_reg[g-1], g);
                    s1c_reg[g] <= s1c_reg[g-1];
                end
            end
        end
    end

    // divide each scaled component by the length, rounded
    dv_t dv0_reg, dv0_next;
    dv_t dv_reg  [DIVN];
    dv_t dv_next [DIVN];

    always_comb
    begin
        dv0_next.neg  = s1c_reg[SQRT_STEPS-1].neg;
        dv0_next.n    = s1c_reg[SQRT_STEPS-1].n;
        dv0_next.eta  = s1c_reg[SQRT_STEPS-1].eta;
        dv0_next.zero = s1c_reg[SQRT_STEPS-1].zero;
        dv0_next.m    = s1_reg[SQRT_STEPS-1].r[DIR_W-1:0];
        dv0_next.q    = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dv0_next.num[i] = {s1c_reg[SQRT_STEPS-1].a[i], FRAC_BITS'(0)}
                              + NUMW'(s1_reg[SQRT_STEPS-1].r[DIR_W-1:1]);
            dv0_next.rem[i] = dv0_next.num[i][NUMW-1 -: DIR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv0_reg <= dv0_next;
    end

    for (genvar j = 0; j < DIVN; j++)
    begin : g_div
        dv_t src;
        if (j == 0)
        begin : g_src0
            assign src = dv0_reg;
        end
        else
        begin : g_srcn
            assign src = dv_reg[j-1];
        end

        always_comb
        begin
            logic [DIR_W:0] st;
            dv_next[j] = src;
            for (int i = 0; i < LANES; i++)
            begin
                st = div_step(src.rem[i], src.m, src.num[i][FRAC_BITS-j]);
                dv_next[j].rem[i]            = st[DIR_W-1:0];
                dv_next[j].q[i][FRAC_BITS-j] = st[DIR_W];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[j] <= dv_next[j];
        end
    end

    // cosine, discriminant
    logic signed [UW-1:0]   u0_reg [LANES];
    logic signed [UW-1:0]   u1_reg [LANES];
    logic signed [UW-1:0]   u2_reg [LANES];
    logic signed [UW-1:0]   u3_reg [LANES];
    logic signed [PW-1:0]   p_reg  [LANES];
    logic signed [NDW-1:0]  nd_reg [LANES];
    logic signed [T_W-1:0]  t4_reg [LANES];
    logic signed [T_W-1:0]  t5_reg [LANES];
    logic [LANES-1:0][NORM_W-1:0] nd0_reg, nd1_reg, nd2_reg, nd3_reg, nd4_reg, nd5_reg;
    logic [ETA_W-1:0]       ed0_reg, ed1_reg, ed2_reg, ed3_reg, ed4_reg, ed5_reg;
    logic [2*ETA_W-1:0]     e2_1_reg, e2_2_reg, e2_3_reg, e2_4_reg;
    logic signed [DT_W-1:0] dt_reg;
    logic signed [DDW-1:0]  dd_reg;
    logic signed [OM_W-1:0] om_reg;
    logic signed [EOW-1:0]  eo_reg;
    logic signed [DOTW-1:0] dot_next;
    logic signed [DDW-1:0]  dt2_next;
    logic signed [EOW-1:0]  disc_next;
    sqs_t                   s2i_next;
    bk_t                    bki_next;
    sqs_t                   s2_reg  [SQRT_STEPS];
    bk_t                    s2c_reg [SQRT_STEPS];
    sqs_t                   s2i_reg;
    bk_t                    bki_reg;

    assign dot_next = DOTW'(p_reg[0]) + DOTW'(p_reg[1]) + DOTW'(p_reg[2]) + DOT_HALF;
    assign dt2_next = (dd_reg + DD_HALF) >>> FRAC_BITS;

    always_comb
    begin
        disc_next    = EO_ONE - ((eo_reg + EO_HALF) >>> (2 * ETA_FRAC));
        bki_next.n   = nd5_reg;
        bki_next.eta = ed5_reg;
        bki_next.pos = disc_next > 0;
        for (int i = 0; i < LANES; i++)
            bki_next.t[i] = t5_reg[i];
        s2i_next.r = '0;
        s2i_next.x = bki_next.pos ? (64'(disc_next) << FRAC_BITS) : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (dv_reg[DIVN-1].zero)
                    u0_reg[i] <= '0;
                else if (dv_reg[DIVN-1].neg[i])
                    u0_reg[i] <= -$signed({1'b0, dv_reg[DIVN-1].q[i]});
                else
                    u0_reg[i] <= $signed({1'b0, dv_reg[DIVN-1].q[i]});
                p_reg[i]  <= $signed(nd0_reg[i]) * u0_reg[i];
                u1_reg[i] <= u0_reg[i];
                u2_reg[i] <= u1_reg[i];
                nd_reg[i] <= $signed(nd2_reg[i]) * dt_reg;
                u3_reg[i] <= u2_reg[i];
                t4_reg[i] <= T_W'(u3_reg[i] - ((nd_reg[i] + ND_HALF) >>> FRAC_BITS));
                t5_reg[i] <= t4_reg[i];
            end
            nd0_reg  <= dv_reg[DIVN-1].n;
            ed0_reg  <= dv_reg[DIVN-1].eta;
            nd1_reg  <= nd0_reg;
            ed1_reg  <= ed0_reg;
            e2_1_reg <= ed0_reg * ed0_reg;
            nd2_reg  <= nd1_reg;
            ed2_reg  <= ed1_reg;
            e2_2_reg <= e2_1_reg;
            dt_reg   <= DT_W'(dot_next >>> FRAC_BITS);
            nd3_reg  <= nd2_reg;
            ed3_reg  <= ed2_reg;
            e2_3_reg <= e2_2_reg;
            dd_reg   <= dt_reg * dt_reg;
            nd4_reg  <= nd3_reg;
            ed4_reg  <= ed3_reg;
            e2_4_reg <= e2_3_reg;
            om_reg   <= OM_W'(DD_ONE - dt2_next);
            nd5_reg  <= nd4_reg;
            ed5_reg  <= ed4_reg;
            eo_reg   <= $signed({1'b0, e2_4_reg}) * om_reg;
            s2i_reg  <= s2i_next;
            bki_reg  <= bki_next;
        end
    end

    // root of the discriminant
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sq2
        if (g == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s2_reg[g]  <= sqrt_step(s2i_reg, g);
                    s2c_reg[g] <= bki_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s2_reg[g]  <= sqrt_step(s2_reg[g-1], g);
                    s2c_reg[g] <= s2c_reg[g-1];
                end
            end
        end
    end

    // combine, saturate
    logic signed [ETW-1:0]   et_reg [LANES];
    logic signed [NSW-1:0]   ns_reg [LANES];
    logic signed [VW-1:0]    v_reg  [LANES];
    logic                    pos0_reg, pos1_reg, ref_reg;
    logic signed [DIR_W-1:0] res_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                et_reg[i] <= $signed({1'b0, s2c_reg[SQRT_STEPS-1].eta})
                             * $signed(s2c_reg[SQRT_STEPS-1].t[i]);
                ns_reg[i] <= $signed(s2c_reg[SQRT_STEPS-1].n[i])
                             * $signed({1'b0, s2_reg[SQRT_STEPS-1].r[SQ_W-1:0]});
                v_reg[i]  <= VW'((et_reg[i] + ET_HALF) >>> ETA_FRAC)
                             - VW'((ns_reg[i] + NS_HALF) >>> FRAC_BITS);
                if (!pos1_reg)
                    res_reg[i] <= '0;
                else if (v_reg[i] > V_MAX)
                    res_reg[i] <= DIR_W'(V_MAX);
                else if (v_reg[i] < V_MIN)
                    res_reg[i] <= DIR_W'(V_MIN);
                else
                    res_reg[i] <= DIR_W'(v_reg[i]);
            end
            pos0_reg <= s2c_reg[SQRT_STEPS-1].pos;
            pos1_reg <= pos0_reg;
            ref_reg  <= pos1_reg;
        end
    end

    assign ray_out.valid     = vld_reg[NST-1];
    assign ray_out.out_x     = res_reg[0];
    assign ray_out.out_y     = res_reg[1];
    assign ray_out.out_z     = res_reg[2];
    assign ray_out.refracted = ref_reg;

    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ray_out.valid && !ray_out.refracted
        |-> ray_out.out_x == 0 && ray_out.out_y == 0 && ray_out.out_z == 0)
        else $error("total internal reflection result not zero");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_DV0-1] && !s1c_reg[SQRT_STEPS-1].zero
        |-> s1_reg[SQRT_STEPS-1].r >= 64'd1 << 30 && s1_reg[SQRT_STEPS-1].r < 64'd1 << 32)
        else $error("direction length out of normalized range");

    a_rem_init: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_DV0] && !dv0_reg.zero
        |-> dv0_reg.rem[0] < dv0_reg.m && dv0_reg.rem[1] < dv0_reg.m
            && dv0_reg.rem[2] < dv0_reg.m)
        else $error("divider quotient would overflow");

    a_unit_quot: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[I_DVL] && !dv_reg[DIVN-1].zero
        |-> dv_reg[DIVN-1].q[0] <= (DIVN'(1) << FRAC_BITS)
            && dv_reg[DIVN-1].q[1] <= (DIVN'(1) << FRAC_BITS)
            && dv_reg[DIVN-1].q[2] <= (DIVN'(1) << FRAC_BITS))
        else $error("normalized component above one");

endmodule

### tb/rrd_tb_scoreboard.sv
class refraction_scoreboard;
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        refracted;
    } ray_result_t;

    ray_result_t pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    static function longint round_shift(longint v, int s);
        longint w;
        w = v + (longint'(1) << (s - 1));
        return w >>> s;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    static function logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function void note_ray(logic signed [31:0] dx, logic signed [31:0] dy,
                           logic signed [31:0] dz, logic signed [17:0] nx,
                           logic signed [17:0] ny, logic signed [17:0] nz,
                           logic [15:0] eta_in);
        longint          d[3];
        longint          n[3];
        longint          u[3];
        longint unsigned a[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned m;
        longint          eta;
        longint          dt;
        longint          dt2;
        longint          om;
        longint          disc;
        longint          sq;
        longint          t;
        longint          v[3];
        int              k;
        ray_result_t     r;
        d[0] = dx; d[1] = dy; d[2] = dz;
        n[0] = nx; n[1] = ny; n[2] = nz;
        eta = eta_in;
        mx = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = 0;
            a[i] = d[i] < 0 ? -d[i] : d[i];
            if (a[i] > mx)
                mx = a[i];
        end
        if (mx != 0)
        begin
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1;
                k++;
            end
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] <<= k;
                sum += a[i] * a[i];
            end
            m = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                t = ((a[i] << 16) + (m >> 1)) / m;
                u[i] = d[i] < 0 ? -t : t;
            end
        end
        dt = round_shift(n[0] * u[0] + n[1] * u[1] + n[2] * u[2], 16);
        dt2 = round_shift(dt * dt, 16);
        om = 65536 - dt2;
        disc = 65536 - round_shift(eta * eta * om, 24);
        if (disc <= 0)
        begin
            r = '{32'd0, 32'd0, 32'd0, 1'b0};
        end
        else
        begin
            sq = int_sqrt(longint'(disc) << 16);
            for (int i = 0; i < 3; i++)
            begin
                t = u[i] - round_shift(n[i] * dt, 16);
                v[i] = round_shift(eta * t, 12) - round_shift(n[i] * sq, 16);
            end
            r = '{clamp32(v[0]), clamp32(v[1]), clamp32(v[2]), 1'b1};
        end
        pending.push_back(r);
    endfunction

    function bit check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic refracted, output string msg);
        ray_result_t e;
        if (pending.size() == 0)
        begin
            msg = $sformatf("unexpected result %h %h %h %b", x, y, z, refracted);
            return 0;
        end
        e = pending.pop_front();
        if (x !== e.x || y !== e.y || z !== e.z || refracted !== e.refracted)
        begin
            msg = $sformatf("got %h %h %h %b exp %h %h %h %b", x, y, z, refracted,
                            e.x, e.y, e.z, e.refracted);
            return 0;
        end
        return 1;
    endfunction
endclass

### tb/tb_top.sv
module tb_top;
    import rrd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_recv;
    int   cycles;
    int   mismatches;

    refraction_scoreboard sb;

    rrd_in_if  ray_in();
    rrd_out_if ray_out();

    ray_refraction_direction dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .ray_in (ray_in.sink),
        .ray_out(ray_out.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic send_ray(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                            logic [15:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            ray_in.valid <= 1'b0;
            @(negedge clk);
        end
        ray_in.valid  <= 1'b1;
        ray_in.dir_x  <= dx;
        ray_in.dir_y  <= dy;
        ray_in.dir_z  <= dz;
        ray_in.norm_x <= nx;
        ray_in.norm_y <= ny;
        ray_in.norm_z <= nz;
        ray_in.eta    <= e;
        @(posedge clk);
        while (!ray_in.ready)
            @(posedge clk);
        sb.note_ray(dx, dy, dz, nx, ny, nz, e);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(131072) - 65536;
            2: return $urandom_range(15) - 8;
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(1 << 21) - (1 << 20);
        endcase
    endfunction

    function automatic logic [17:0] rand_norm(int k);
        case ($urandom_range(3))
            0: return 18'($urandom);
            1: return 18'($urandom_range(131072) - 65536);
            default: return k == 2 ? 18'(65536 - $urandom_range(4000))
                                   : 18'($urandom_range(16000) - 8000);
        endcase
    endfunction

    function automatic logic [15:0] rand_eta();
        case ($urandom_range(3))
            0: return 16'($urandom);
            default: return 16'($urandom_range(2048, 6144));
        endcase
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_ray(rand_dir(), rand_dir(), rand_dir(), rand_norm(0), rand_norm(1),
                     rand_norm(2), rand_eta());
    endtask

    task automatic drain();
        ray_in.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        string msg;
        forever
        begin
            @(posedge clk);
            if (ray_out.valid && ray_out.ready)
                if (!sb.check_result(ray_out.out_x, ray_out.out_y, ray_out.out_z,
                                     ray_out.refracted, msg))
                    report(msg);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout");
                $display("** ray_refraction_direction: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            ray_out.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        sb = new();
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 0;
        ray_in.valid = 0;
        ray_in.dir_x = 0;
        ray_in.dir_y = 0;
        ray_in.dir_z = 0;
        ray_in.norm_x = 0;
        ray_in.norm_y = 0;
        ray_in.norm_z = 0;
        ray_in.eta = 0;
        ray_out.ready = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // zero direction, eta both sides of one, extremes
        send_ray(0, 0, 0, 0, 0, 18'h10000, 16'h1000);
        send_ray(0, 0, 0, 0, 0, 18'h10000, 16'h2000);
        send_ray(0, 0, 0, 0, 0, 18'h10000, 16'h0800);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h1ffff, 18'h1ffff,
                 18'h1ffff, 16'hffff);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 18'h20000, 18'h20000,
                 18'h20000, 16'hffff);
        send_ray(32'h80000000, 0, 0, 18'h10000, 0, 0, 16'h1000);
        send_ray(1, 0, 0, 0, 0, 18'h10000, 16'h1000);
        send_ray(32'hffffffff, 1, 32'h7fffffff, 18'h30000, 0, 0, 0);
        send_ray(0, 0, 32'hffff0000, 0, 0, 18'h10000, 16'h1555);
        send_ray(0, 32'h00010000, 32'hffff0000, 0, 0, 18'h10000, 16'h1800);
        send_ray(32'h00010000, 0, 32'hffff0000, 0, 0, 18'h10000, 16'h0aab);
        send_ray(32'h00010000, 0, 32'hffff0000, 0, 0, 18'h10000, 16'h2000);
        send_ray(32'h00008000, 0, 32'hffff0000, 0, 0, 18'h10000, 16'h1000);
        send_ray(32'h7fffffff, 0, 32'h80000000, 18'h1ffff, 18'h20000, 18'h1ffff, 16'hffff);
        send_ray(5, 32'hfffffffd, 7, 18'h00100, 18'h3ff00, 18'h10000, 16'h0001);
        drain();

        send_random(300);
        send_idle_pct = 81;
        send_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        send_random(250);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        send_random(250);

        fork
            begin
                hold_recv = 1;
                repeat (300) @(negedge clk);
                hold_recv = 0;
            end
            send_random(150);
        join
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(100);

        drain();
        repeat (150) @(negedge clk);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("** ray_refraction_direction: PASSED **");
        else
            $display("** ray_refraction_direction: FAILED **");
        $finish;
    end
endmodule
